// File: rtl/core/lesf_pkg.sv
// lesf_pkg: shared constants, types and register indexes of the largest
// empty square finder
// no dependencies
package lesf_pkg;

  // grid limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int CNT_W      = 11;
  localparam int COL_AW     = $clog2(MAX_COLS);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // largest score before saturation
  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CHAR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COL_TOTAL     = CFG_IDX_W'(3);

  // cell class decided by the front
  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_OBST,
    CLS_BAD
  } cls_t;

  // one classified cell travelling from front to back
  typedef struct packed {
    cls_t             cls;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             border;
    logic             last_col;
    logic             done;
  } item_t;

endpackage

// File: rtl/core/lesf_if.sv
// lesf_if: valid/ready channel interfaces for cells, results and configuration
// depends on lesf_pkg

// cell request channel
interface lesf_cell_if;
  logic                         valid;
  logic                         ready;
  logic [lesf_pkg::CHAR_W-1:0]  cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink (input valid, input cell_char, output ready);
endinterface

// result request channel
interface lesf_res_if;
  logic                         valid;
  logic                         ready;
  logic [lesf_pkg::SIZE_W-1:0]  cell_size;
  logic                         map_done;
  logic                         bad_char_seen;
  logic [lesf_pkg::POS_W-1:0]   best_row;
  logic [lesf_pkg::POS_W-1:0]   best_col;
  logic [lesf_pkg::SIZE_W-1:0]  best_size;

  modport source (output valid, output cell_size, output map_done,
                  output bad_char_seen, output best_row, output best_col,
                  output best_size, input ready);
  modport sink (input valid, input cell_size, input map_done,
                input bad_char_seen, input best_row, input best_col,
                input best_size, output ready);
endinterface

// configuration write channel
interface lesf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lesf_pkg::CFG_IDX_W-1:0]   index;
  logic [lesf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/lesf_ram.sv
// lesf_ram: generic single write port, single read port ram with registered read
// no dependencies
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lesf_front.sv
// lesf_front: configuration registers, cell classification and raster position
// depends on lesf_pkg and lesf_if
module lesf_front (
  input  logic                clk,
  input  logic                rst,
  lesf_cell_if.sink           cell_in,
  lesf_cfg_if.sink            cfg,
  output logic                push,
  output lesf_pkg::item_t     push_item,
  input  logic                q_full
);

  logic [lesf_pkg::CHAR_W-1:0] empty_char;
  logic [lesf_pkg::CHAR_W-1:0] obstacle_char;
  logic [lesf_pkg::CNT_W-1:0]  row_count;
  logic [lesf_pkg::CNT_W-1:0]  col_total;
  logic [lesf_pkg::POS_W-1:0]  row_pos;
  logic [lesf_pkg::POS_W-1:0]  col_pos;
  logic [lesf_pkg::POS_W-1:0]  row_pos_next;
  logic [lesf_pkg::POS_W-1:0]  col_pos_next;
  logic [lesf_pkg::CNT_W-1:0]  rows;
  logic [lesf_pkg::CNT_W-1:0]  cols;
  logic                        last_col;
  logic                        last_row;

  // take a cell whenever the queue has room; config is always taken
  assign cell_in.ready = !q_full;
  assign cfg.ready     = 1'b1;
  assign push          = cell_in.valid && !q_full;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_char    <= lesf_pkg::CHAR_W'(46);
      obstacle_char <= lesf_pkg::CHAR_W'(111);
      row_count     <= lesf_pkg::CNT_W'(1);
      col_total     <= lesf_pkg::CNT_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lesf_pkg::REG_EMPTY_CHAR:    empty_char    <= cfg.data[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::REG_OBSTACLE_CHAR: obstacle_char <= cfg.data[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::REG_ROW_COUNT:     row_count     <= cfg.data[lesf_pkg::CNT_W-1:0];
        lesf_pkg::REG_COL_TOTAL:     col_total     <= cfg.data[lesf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts, end of row and map, classify and step position
  always_comb begin
    if (row_count == '0) begin
      rows = lesf_pkg::CNT_W'(1);
    end else if (row_count > lesf_pkg::CNT_W'(lesf_pkg::MAX_ROWS)) begin
      rows = lesf_pkg::CNT_W'(lesf_pkg::MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (col_total == '0) begin
      cols = lesf_pkg::CNT_W'(1);
    end else if (col_total > lesf_pkg::CNT_W'(lesf_pkg::MAX_COLS)) begin
      cols = lesf_pkg::CNT_W'(lesf_pkg::MAX_COLS);
    end else begin
      cols = col_total;
    end

    last_col = (lesf_pkg::CNT_W'(col_pos) + lesf_pkg::CNT_W'(1)) >= cols;
    last_row = (lesf_pkg::CNT_W'(row_pos) + lesf_pkg::CNT_W'(1)) >= rows;

    // obstacle wins when both codes match
    if (cell_in.cell_char == obstacle_char) begin
      push_item.cls = lesf_pkg::CLS_OBST;
    end else if (cell_in.cell_char == empty_char) begin
      push_item.cls = lesf_pkg::CLS_EMPTY;
    end else begin
      push_item.cls = lesf_pkg::CLS_BAD;
    end
    push_item.row      = row_pos;
    push_item.col      = col_pos;
    push_item.border   = (row_pos == '0) || (col_pos == '0);
    push_item.last_col = last_col;
    push_item.done     = last_col && last_row;

    if (last_col && last_row) begin
      row_pos_next = '0;
      col_pos_next = '0;
    end else if (last_col) begin
      row_pos_next = row_pos + lesf_pkg::POS_W'(1);
      col_pos_next = '0;
    end else begin
      row_pos_next = row_pos;
      col_pos_next = col_pos + lesf_pkg::POS_W'(1);
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (push) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

endmodule

// File: rtl/core/lesf_queue.sv
// lesf_queue: short first-in first-out queue of classified cells
// depends on lesf_pkg
module lesf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lesf_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lesf_pkg::item_t  head
);

  localparam int PTR_W = (lesf_pkg::Q_DEPTH > 1) ? $clog2(lesf_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(lesf_pkg::Q_DEPTH + 1);

  lesf_pkg::item_t   slots [lesf_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(lesf_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lesf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lesf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // no overflow or underflow
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop) else $error("queue popped while empty");

endmodule

// File: rtl/core/lesf_back.sv
// lesf_back: line store read, cell scoring, best square tracking and result register
// depends on lesf_pkg, lesf_if and lesf_ram
module lesf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  lesf_pkg::item_t  q_head,
  output logic             pop,
  lesf_res_if.source       res_out
);

  // read stage: line store data arrives while the cell sits here
  logic                          x_valid;
  lesf_pkg::item_t               x_item;
  logic                          x_fwd;
  logic [lesf_pkg::SIZE_W-1:0]   x_fwd_val;
  logic                          x_adv;

  // running map state
  logic [lesf_pkg::SIZE_W-1:0]   left_size;
  logic [lesf_pkg::SIZE_W-1:0]   upleft_size;
  logic [lesf_pkg::POS_W-1:0]    max_row;
  logic [lesf_pkg::POS_W-1:0]    max_col;
  logic [lesf_pkg::SIZE_W-1:0]   max_size;
  logic                          error_flag;

  logic [lesf_pkg::SIZE_W-1:0]   rd_data;
  logic [lesf_pkg::SIZE_W-1:0]   top;
  logic [lesf_pkg::SIZE_W-1:0]   min_size;
  logic [lesf_pkg::SIZE_W-1:0]   score;
  logic [lesf_pkg::POS_W-1:0]    max_row_next;
  logic [lesf_pkg::POS_W-1:0]    max_col_next;
  logic [lesf_pkg::SIZE_W-1:0]   max_size_next;
  logic                          error_flag_next;

  // output register
  logic                          out_valid;

  assign x_adv = x_valid && (!out_valid || res_out.ready);
  assign pop   = q_not_empty && (!x_valid || x_adv);
  assign res_out.valid = out_valid;

  // previous row of scores
  lesf_ram #(
    .WIDTH (lesf_pkg::SIZE_W),
    .DEPTH (lesf_pkg::MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (x_adv),
    .waddr (x_item.col[lesf_pkg::COL_AW-1:0]),
    .wdata (score),
    .re    (pop),
    .raddr (q_head.col[lesf_pkg::COL_AW-1:0]),
    .rdata (rd_data)
  );

  // score of the cell and best square so far
  always_comb begin
    top = x_fwd ? x_fwd_val : rd_data;
    min_size = top;
    if (left_size < min_size) begin
      min_size = left_size;
    end
    if (upleft_size < min_size) begin
      min_size = upleft_size;
    end

    unique case (x_item.cls)
      lesf_pkg::CLS_EMPTY: begin
        if (x_item.border) begin
          score = lesf_pkg::SIZE_W'(1);
        end else if (min_size == lesf_pkg::SIZE_SAT) begin
          score = lesf_pkg::SIZE_SAT;
        end else begin
          score = min_size + lesf_pkg::SIZE_W'(1);
        end
      end
      default: score = '0;
    endcase

    error_flag_next = error_flag || (x_item.cls == lesf_pkg::CLS_BAD);
    if (score > max_size) begin
      max_size_next = score;
      max_row_next  = x_item.row;
      max_col_next  = x_item.col;
    end else begin
      max_size_next = max_size;
      max_row_next  = max_row;
      max_col_next  = max_col;
    end
  end

  // read stage occupancy and same-column forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (pop) begin
      x_valid <= 1'b1;
    end else if (x_adv) begin
      x_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_item    <= q_head;
      x_fwd     <= x_adv && (x_item.col == q_head.col);
      x_fwd_val <= score;
    end
  end

  // map state, cleared at the end of each map
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size   <= '0;
      upleft_size <= '0;
      max_row     <= '0;
      max_col     <= '0;
      max_size    <= '0;
      error_flag  <= 1'b0;
    end else if (x_adv) begin
      if (x_item.done) begin
        left_size   <= '0;
        upleft_size <= '0;
        max_row     <= '0;
        max_col     <= '0;
        max_size    <= '0;
        error_flag  <= 1'b0;
      end else begin
        if (x_item.last_col) begin
          left_size   <= '0;
          upleft_size <= '0;
        end else begin
          left_size   <= score;
          upleft_size <= top;
        end
        max_row    <= max_row_next;
        max_col    <= max_col_next;
        max_size   <= max_size_next;
        error_flag <= error_flag_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (x_adv) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_adv) begin
      res_out.cell_size     <= score;
      res_out.map_done      <= x_item.done;
      res_out.bad_char_seen <= error_flag_next;
      res_out.best_row      <= max_row_next;
      res_out.best_col      <= max_col_next;
      res_out.best_size     <= max_size_next;
    end
  end

  // no new read while the read stage is stuck
  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    (x_valid && !x_adv) |-> !pop) else $error("line store read while stalled");
  // best size never shrinks within a map
  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    (x_adv && !x_item.done) |=> (max_size >= $past(max_size)))
    else $error("best size shrank inside a map");
  // end of map clears the running state
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (x_adv && x_item.done) |=> (max_size == '0 && !error_flag && left_size == '0))
    else $error("map state not cleared after last cell");
  // a cell never beats the best square reported with it
  a_cell_le_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_out.cell_size <= res_out.best_size))
    else $error("cell size above best size");

endmodule

// File: rtl/core/largest_empty_square_finder.sv
// largest_empty_square_finder: top level joining front, queue and back
// depends on lesf_pkg, lesf_if, lesf_front, lesf_queue, lesf_back
//
//   channel   dir  carries                                        taken when
//   cell_in   in   cell_char                                      valid && ready
//   res_out   out  cell_size map_done bad_char_seen best_row/col  valid && ready
//                  best_size
//   cfg       in   index (0 empty, 1 obstacle, 2 rows, 3 cols),   valid && ready
//                  data
//
// one cell per cycle sustained while results are taken; a result passes through
// the queue slot and the line store read stage and waits in the result register
// the line store has one write and one read port, read one cell ahead
// synchronous reset clears control and map state; the line store is not cleared
// a stalled result holds the back, the two-entry queue then fills and drops
// cell_in.ready; cfg.ready is always high
module largest_empty_square_finder (
  input  logic        clk,
  input  logic        rst,
  lesf_cell_if.sink   cell_in,
  lesf_res_if.source  res_out,
  lesf_cfg_if.sink    cfg
);

  logic             push;
  lesf_pkg::item_t  push_item;
  logic             q_full;
  logic             q_not_empty;
  lesf_pkg::item_t  q_head;
  logic             pop;

  // classification and position
  lesf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_in),
    .cfg       (cfg),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  lesf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // scoring and results
  lesf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .res_out     (res_out)
  );

endmodule
